>>> sv/drs_pkg.sv
// Package for the disk request scheduler: command, status, policy and state codes,
// the control structs that pass between the cells, the picker and the controller,
// and the default sizes. It depends on nothing else.
package drs_pkg;

    localparam int unsigned DEF_QUEUE_DEPTH = 16;
    localparam int unsigned DEF_BLOCK_BITS  = 16;
    localparam int unsigned FIELD_BITS      = 16;
    localparam int unsigned CFG_ADDR_W      = 3;
    localparam int unsigned CFG_DATA_W      = 32;

    typedef enum logic {
        CMD_INSERT   = 1'b0,
        CMD_DISPATCH = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_INSERTED   = 2'd0,
        ST_DISPATCHED = 2'd1,
        ST_FULL       = 2'd2,
        ST_EMPTY      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        POL_FIFO  = 2'd0,
        POL_SSTF  = 2'd1,
        POL_CLOOK = 2'd2
    } t_policy;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_REMOVE
    } t_state;

    typedef enum logic {
        REG_POLICY = 1'b0
    } t_reg_index;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctrl;

    typedef struct packed {
        logic sample;
        logic first;
    } t_pick_ctrl;

endpackage

>>> sv/drs_cell.sv
// One cell of the request ring: holds one queued block number.
// It takes its neighbour's entry on a shift or the new request on a load.
// Depends on drs_pkg for the control struct.
module drs_cell #(
    parameter int unsigned BLOCK_BITS = drs_pkg::DEF_BLOCK_BITS
) (
    input  logic                   i_clk,
    input  drs_pkg::t_cell_ctrl    i_ctrl,
    input  logic [BLOCK_BITS-1:0]  i_wr_data,
    input  logic [BLOCK_BITS-1:0]  i_next_data,
    output logic [BLOCK_BITS-1:0]  o_data
);
    import drs_pkg::*;

    logic [BLOCK_BITS-1:0] r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_entry <= i_next_data;
        end else if (i_ctrl.load) begin
            r_entry <= i_wr_data;
        end
    end

    assign o_data = r_entry;

endmodule

>>> sv/drs_picker.sv
// Selection unit at the front of the ring: sees one entry per cycle and keeps the
// best candidate for each policy, with ties going to the oldest entry.
// Depends on drs_pkg for the policy codes and the control struct.
module drs_picker #(
    parameter int unsigned BLOCK_BITS = drs_pkg::DEF_BLOCK_BITS,
    parameter int unsigned IDX_W      = 4
) (
    input  logic                   i_clk,
    input  drs_pkg::t_pick_ctrl    i_ctrl,
    input  drs_pkg::t_policy       i_policy,
    input  logic [IDX_W-1:0]       i_step,
    input  logic [BLOCK_BITS-1:0]  i_head,
    input  logic [BLOCK_BITS-1:0]  i_data,
    output logic [IDX_W-1:0]       o_idx,
    output logic [BLOCK_BITS-1:0]  o_block
);
    import drs_pkg::*;

    logic [BLOCK_BITS-1:0] r_first_val;
    logic [IDX_W-1:0]      r_best_idx;
    logic [BLOCK_BITS-1:0] r_best_val;
    logic [BLOCK_BITS-1:0] r_best_dist;
    logic [IDX_W-1:0]      r_low_idx;
    logic [BLOCK_BITS-1:0] r_low_val;
    logic [IDX_W-1:0]      r_up_idx;
    logic [BLOCK_BITS-1:0] r_up_val;
    logic                  r_up_found;

    logic [BLOCK_BITS-1:0] w_dist;
    logic                  w_take_best;
    logic                  w_take_low;
    logic                  w_take_up;

    always_comb begin
        w_dist      = (i_data > i_head) ? (i_data - i_head) : (i_head - i_data);
        w_take_best = i_ctrl.first || (w_dist < r_best_dist);
        w_take_low  = i_ctrl.first || (i_data < r_low_val);
        w_take_up   = (i_data >= i_head) &&
                      (i_ctrl.first || !r_up_found || (i_data < r_up_val));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.sample) begin
            if (i_ctrl.first) begin
                r_first_val <= i_data;
                r_up_found  <= 1'b0;
            end
            if (w_take_best) begin
                r_best_idx  <= i_step;
                r_best_val  <= i_data;
                r_best_dist <= w_dist;
            end
            if (w_take_low) begin
                r_low_idx <= i_step;
                r_low_val <= i_data;
            end
            if (w_take_up) begin
                r_up_idx   <= i_step;
                r_up_val   <= i_data;
                r_up_found <= 1'b1;
            end
        end
    end

    always_comb begin
        unique case (i_policy)
            POL_SSTF: begin
                o_idx   = r_best_idx;
                o_block = r_best_val;
            end
            POL_CLOOK: begin
                o_idx   = r_up_found ? r_up_idx : r_low_idx;
                o_block = r_up_found ? r_up_val : r_low_val;
            end
            default: begin
                o_idx   = '0;
                o_block = r_first_val;
            end
        endcase
    end

endmodule

>>> sv/disk_request_scheduler.sv
// Disk request scheduler: a queue of up to QUEUE_DEPTH block numbers held in a ring of
// cells. An insert item is answered straight from the idle state. A dispatch item on
// a non-empty queue goes through the states in order: the idle state accepts it, the
// scan state rotates the whole ring once past the picker at its front, and the remove
// state closes the gap left by the chosen entry. Inserts into a full queue and
// dispatches from an empty queue are also answered straight from the idle state.
// Results wait in an output register; a new item is taken when the sequencer is idle
// and that register is free or is being emptied. The policy register is at address 0
// of the APB-style port. Depends on drs_pkg, drs_cell and drs_picker.
module disk_request_scheduler #(
    parameter int unsigned QUEUE_DEPTH = drs_pkg::DEF_QUEUE_DEPTH,
    parameter int unsigned BLOCK_BITS  = drs_pkg::DEF_BLOCK_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_cmd,
    input  logic [drs_pkg::FIELD_BITS-1:0]      i_request_block,
    input  logic [drs_pkg::FIELD_BITS-1:0]      i_head_position,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [1:0]                          o_status,
    output logic [drs_pkg::FIELD_BITS-1:0]      o_chosen_block,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]    o_pending,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [drs_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [drs_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [drs_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import drs_pkg::*;

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned MIN_W = (BLOCK_BITS < FIELD_BITS) ? BLOCK_BITS : FIELD_BITS;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [IDX_W-1:0]      r_step, n_step;
    logic [BLOCK_BITS-1:0] r_head;
    t_policy               r_policy;
    logic                  r_out_valid;
    t_status               r_out_status;
    logic [BLOCK_BITS-1:0] r_out_block;
    logic [CNT_W-1:0]      r_out_pending;

    logic                  w_in_fire;
    logic [BLOCK_BITS-1:0] w_blk;
    logic [BLOCK_BITS-1:0] w_head;
    logic                  w_load_out;
    t_status               w_out_status;
    logic [BLOCK_BITS-1:0] w_out_block;
    logic                  w_cell_load;
    logic                  w_rotate;
    logic                  w_remove;
    t_pick_ctrl            w_pick_ctrl;
    logic [IDX_W-1:0]      w_pick_idx;
    logic [BLOCK_BITS-1:0] w_pick_block;
    logic                  w_cfg_wr;

    logic [BLOCK_BITS-1:0] w_cell_data [QUEUE_DEPTH];
    t_cell_ctrl            w_cell_ctrl [QUEUE_DEPTH];

    assign o_ready   = (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign w_in_fire = i_valid && o_ready;

    always_comb begin
        w_blk               = '0;
        w_head              = '0;
        w_blk[MIN_W-1:0]    = i_request_block[MIN_W-1:0];
        w_head[MIN_W-1:0]   = i_head_position[MIN_W-1:0];
    end

    // Configuration port.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_POLICY);

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_POLICY) begin
            prdata[1:0] = r_policy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_FIFO;
        end else if (w_cfg_wr) begin
            r_policy <= t_policy'(pwdata[1:0]);
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_head <= w_head;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_step       = r_step;
        w_load_out   = 1'b0;
        w_out_status = ST_INSERTED;
        w_out_block  = '0;
        w_cell_load  = 1'b0;
        w_rotate     = 1'b0;
        w_remove     = 1'b0;
        w_pick_ctrl  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    if (t_cmd'(i_cmd) == CMD_INSERT) begin
                        w_load_out = 1'b1;
                        if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                            w_out_status = ST_FULL;
                        end else begin
                            w_cell_load  = 1'b1;
                            n_count      = r_count + 1'b1;
                            w_out_status = ST_INSERTED;
                        end
                    end else if (r_count == '0) begin
                        w_load_out   = 1'b1;
                        w_out_status = ST_EMPTY;
                    end else begin
                        n_state = S_SCAN;
                        n_step  = '0;
                    end
                end
            end
            S_SCAN: begin
                w_rotate           = 1'b1;
                w_pick_ctrl.sample = (CNT_W'(r_step) < r_count);
                w_pick_ctrl.first  = (r_step == '0);
                n_step             = r_step + 1'b1;
                if (r_step == IDX_W'(QUEUE_DEPTH - 1)) begin
                    n_state = S_REMOVE;
                end
            end
            S_REMOVE: begin
                w_remove     = 1'b1;
                n_count      = r_count - 1'b1;
                w_load_out   = 1'b1;
                w_out_status = ST_DISPATCHED;
                w_out_block  = w_pick_block;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Ring of cells; cell 0 holds the oldest entry and faces the picker.
    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
        always_comb begin
            w_cell_ctrl[k].load  = w_cell_load && (r_count == CNT_W'(k));
            w_cell_ctrl[k].shift = w_rotate ||
                                   (w_remove && (w_pick_idx <= IDX_W'(k)) &&
                                    (k < QUEUE_DEPTH - 1));
        end

        drs_cell #(
            .BLOCK_BITS (BLOCK_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_cell_ctrl[k]),
            .i_wr_data   (w_blk),
            .i_next_data (w_cell_data[(k + 1) % QUEUE_DEPTH]),
            .o_data      (w_cell_data[k])
        );
    end

    drs_picker #(
        .BLOCK_BITS (BLOCK_BITS),
        .IDX_W      (IDX_W)
    ) u_picker (
        .i_clk    (i_clk),
        .i_ctrl   (w_pick_ctrl),
        .i_policy (r_policy),
        .i_step   (r_step),
        .i_head   (r_head),
        .i_data   (w_cell_data[0]),
        .o_idx    (w_pick_idx),
        .o_block  (w_pick_block)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_status  <= w_out_status;
            r_out_block   <= w_out_block;
            r_out_pending <= n_count;
        end
    end

    always_comb begin
        o_chosen_block              = '0;
        o_chosen_block[MIN_W-1:0]   = r_out_block[MIN_W-1:0];
    end

    assign o_valid   = r_out_valid;
    assign o_status  = r_out_status;
    assign o_pending = r_out_pending;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    a_dispatch_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && (t_cmd'(i_cmd) == CMD_DISPATCH) && (r_count != '0))
        |=> (r_state == S_SCAN))
        else $error("dispatch on a non-empty queue did not start a scan");

    a_remove_decrements: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REMOVE) |=> (r_count == $past(r_count) - 1'b1))
        else $error("removal did not shorten the queue by one");

    a_out_free_on_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REMOVE) |-> !r_out_valid)
        else $error("dispatch result would overwrite a waiting item");

    a_pick_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REMOVE) |-> (CNT_W'(w_pick_idx) < r_count))
        else $error("picked entry lies beyond the queued entries");
`endif

endmodule
